// File: hdl/ttlcpu_pkg.sv
// Shared types and constants for the eight-bit TTL Harvard CPU cycle block.
`default_nettype none
package ttlcpu_pkg;

	// Size of the data RAM in bytes; addresses at or above it read as zero.
	localparam int RAM_BYTES = 32768;
	localparam int RAM_AW    = $clog2(RAM_BYTES);

	localparam logic [7:0] OPC_NOP  = 8'h02;
	localparam int         SYNC_BIT = 6;

	typedef enum logic [2:0] {
		OP_LD  = 3'd0,
		OP_AND = 3'd1,
		OP_OR  = 3'd2,
		OP_XOR = 3'd3,
		OP_ADD = 3'd4,
		OP_SUB = 3'd5,
		OP_ST  = 3'd6,
		OP_BR  = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		MODE_D      = 3'd0,
		MODE_X      = 3'd1,
		MODE_YD     = 3'd2,
		MODE_YX     = 3'd3,
		MODE_XREG   = 3'd4,
		MODE_YREG   = 3'd5,
		MODE_OUT    = 3'd6,
		MODE_OUTINC = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		BUS_D   = 2'd0,
		BUS_RAM = 2'd1,
		BUS_AC  = 2'd2,
		BUS_IN  = 2'd3
	} bus_t;

	typedef enum logic [2:0] {
		TGT_NONE,
		TGT_AC,
		TGT_X,
		TGT_Y,
		TGT_OUT
	} tgt_t;

endpackage
`default_nettype wire

// File: hdl/ttlcpu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module ttlcpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/ttl_harvard_cpu_cycle.sv
// Eight-bit TTL Harvard CPU, one machine cycle per input word.
// Latency: the result word for an accepted input word is valid on the next cycle.
// Throughput: one word per cycle; s_axis_tready drops only while a result waits unread.
// The RAM operand of each instruction is read ahead, as its word is accepted, from the
// next-state values, so the data RAM's registered read is ready when it executes.
// Reset clears every register but fwd_data_q and loads a nop; data RAM is not cleared.
`default_nettype none
module ttl_harvard_cpu_cycle (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// [15:0] rom_word, [23:16] input_port
	input  wire logic [23:0] s_axis_tdata,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [15:0] fetch_address, [23:16] out_port, [31:24] xout_port, [39:32] acc_value,
	// [47:40] x_value, [55:48] y_value
	output      logic [55:0] m_axis_tdata
);

	logic [15:0] pc_q;
	logic [7:0]  ir_q, d_q, ac_q, x_q, y_q, out_q, xout_q, in_q;
	logic        sync_q;
	logic        m_valid_q;
	logic        fwd_q;
	logic [7:0]  fwd_data_q;
	logic        oor_q;

	logic                          acc_en;
	ttlcpu_pkg::op_t               op;
	ttlcpu_pkg::mode_t             mode;
	ttlcpu_pkg::bus_t              bus;
	ttlcpu_pkg::tgt_t              tgt;
	logic                          is_store, is_branch, inc_x;
	logic [15:0]                   cur_addr, rd_addr;
	logic [7:0]                    ram_rdata, b, alu;
	logic [8:0]                    sum;
	logic [3:0]                    cond_vec;
	logic [1:0]                    cond;
	logic [15:0]                   pc_nx;
	logic [7:0]                    x_nx, y_nx, ac_nx, out_nx;
	logic                          ram_we;

	function automatic logic [15:0] mem_addr(input logic [7:0] ir, input logic [7:0] d,
			input logic [7:0] x, input logic [7:0] y);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = d;
		hi = 8'h00;
		if (ttlcpu_pkg::op_t'(ir[7:5]) != ttlcpu_pkg::OP_BR) begin
			unique case (ttlcpu_pkg::mode_t'(ir[4:2]))
				ttlcpu_pkg::MODE_X: lo = x;
				ttlcpu_pkg::MODE_YD: hi = y;
				ttlcpu_pkg::MODE_YX, ttlcpu_pkg::MODE_OUTINC: begin
					lo = x;
					hi = y;
				end
				default: ;
			endcase
		end
		return {hi, lo};
	endfunction

	function automatic logic in_range(input logic [15:0] a);
		return ({1'b0, a} < 17'(ttlcpu_pkg::RAM_BYTES));
	endfunction

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign acc_en        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {y_q, x_q, ac_q, xout_q, out_q, pc_q};

	assign op        = ttlcpu_pkg::op_t'(ir_q[7:5]);
	assign mode      = ttlcpu_pkg::mode_t'(ir_q[4:2]);
	assign bus       = ttlcpu_pkg::bus_t'(ir_q[1:0]);
	assign is_store  = (op == ttlcpu_pkg::OP_ST);
	assign is_branch = (op == ttlcpu_pkg::OP_BR);
	assign cur_addr  = mem_addr(ir_q, d_q, x_q, y_q);

	always_comb begin
		tgt   = ttlcpu_pkg::TGT_NONE;
		inc_x = 1'b0;
		if (!is_branch) begin
			unique case (mode)
				ttlcpu_pkg::MODE_D, ttlcpu_pkg::MODE_X, ttlcpu_pkg::MODE_YD,
				ttlcpu_pkg::MODE_YX:
					tgt = is_store ? ttlcpu_pkg::TGT_NONE : ttlcpu_pkg::TGT_AC;
				ttlcpu_pkg::MODE_XREG: tgt = ttlcpu_pkg::TGT_X;
				ttlcpu_pkg::MODE_YREG: tgt = ttlcpu_pkg::TGT_Y;
				ttlcpu_pkg::MODE_OUT:
					tgt = is_store ? ttlcpu_pkg::TGT_NONE : ttlcpu_pkg::TGT_OUT;
				ttlcpu_pkg::MODE_OUTINC: begin
					tgt   = is_store ? ttlcpu_pkg::TGT_NONE : ttlcpu_pkg::TGT_OUT;
					inc_x = 1'b1;
				end
			endcase
		end
	end

	// A store to the very byte being read ahead is forwarded past the RAM.
	always_comb begin
		unique case (bus)
			ttlcpu_pkg::BUS_D:   b = d_q;
			ttlcpu_pkg::BUS_RAM: b = (is_store || oor_q) ? 8'h00
				: (fwd_q ? fwd_data_q : ram_rdata);
			ttlcpu_pkg::BUS_AC:  b = ac_q;
			ttlcpu_pkg::BUS_IN:  b = in_q;
		endcase
	end

	always_comb begin
		sum = 9'h000;
		unique case (op)
			ttlcpu_pkg::OP_LD:  alu = b;
			ttlcpu_pkg::OP_AND: alu = ac_q & b;
			ttlcpu_pkg::OP_OR:  alu = ac_q | b;
			ttlcpu_pkg::OP_XOR: alu = ac_q ^ b;
			ttlcpu_pkg::OP_ADD: begin
				sum = {1'b0, ac_q} + {1'b0, b};
				alu = sum[7:0];
			end
			ttlcpu_pkg::OP_SUB: begin
				sum = {1'b0, ac_q} - {1'b0, b};
				alu = sum[7:0];
			end
			ttlcpu_pkg::OP_ST, ttlcpu_pkg::OP_BR: alu = ac_q;
		endcase
	end

	// Condition index: sign bit in bit 0, zero flag in bit 1.
	assign cond     = {(ac_q == 8'h00), ac_q[7]};
	assign cond_vec = {1'b0, mode};

	always_comb begin
		pc_nx = pc_q + 16'd1;
		if (is_branch) begin
			if (mode == ttlcpu_pkg::MODE_D) begin
				pc_nx = {y_q, b};
			end else if (cond_vec[cond]) begin
				pc_nx = {pc_q[15:8], b};
			end
		end
	end

	always_comb begin
		ac_nx  = (tgt == ttlcpu_pkg::TGT_AC) ? alu : ac_q;
		y_nx   = (tgt == ttlcpu_pkg::TGT_Y) ? alu : y_q;
		out_nx = (tgt == ttlcpu_pkg::TGT_OUT) ? alu : out_q;
		if (tgt == ttlcpu_pkg::TGT_X) begin
			x_nx = alu;
		end else if (inc_x) begin
			x_nx = x_q + 8'd1;
		end else begin
			x_nx = x_q;
		end
	end

	// Operand address of the instruction being latched, taken from next-state values.
	assign rd_addr = mem_addr(s_axis_tdata[7:0], s_axis_tdata[15:8], x_nx, y_nx);
	assign ram_we  = acc_en && is_store && in_range(cur_addr);

	ttlcpu_ram #(
		.WIDTH(8),
		.DEPTH(ttlcpu_pkg::RAM_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cur_addr[ttlcpu_pkg::RAM_AW-1:0]),
		.wdata(b),
		.re   (acc_en),
		.raddr(rd_addr[ttlcpu_pkg::RAM_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 16'h0000;
			ir_q      <= ttlcpu_pkg::OPC_NOP;
			d_q       <= 8'h00;
			ac_q      <= 8'h00;
			x_q       <= 8'h00;
			y_q       <= 8'h00;
			out_q     <= 8'h00;
			xout_q    <= 8'h00;
			in_q      <= 8'h00;
			sync_q    <= 1'b0;
			m_valid_q <= 1'b0;
			fwd_q     <= 1'b0;
			oor_q     <= 1'b0;
		end else begin
			if (acc_en) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (acc_en) begin
				pc_q  <= pc_nx;
				ir_q  <= s_axis_tdata[7:0];
				d_q   <= s_axis_tdata[15:8];
				ac_q  <= ac_nx;
				x_q   <= x_nx;
				y_q   <= y_nx;
				out_q <= out_nx;
				// The edge on the output bit is seen late, from the registered out_q.
				if (out_q[ttlcpu_pkg::SYNC_BIT] && !sync_q) begin
					xout_q <= ac_q;
					in_q   <= s_axis_tdata[23:16];
				end
				sync_q <= out_q[ttlcpu_pkg::SYNC_BIT];
				fwd_q  <= ram_we && (rd_addr == cur_addr);
				oor_q  <= !in_range(rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			fwd_data_q <= b;
		end
	end

	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_en && !is_branch) |=> (pc_q == $past(pc_q) + 16'd1))
		else $error("program counter did not step on a non-branch word");

	a_fwd_store: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_en && !ram_we) |=> !fwd_q)
		else $error("forwarding set without a RAM write");

	a_we_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (acc_en && is_store && in_range(cur_addr)))
		else $error("RAM write outside a store or beyond the RAM");

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the eight-bit TTL Harvard CPU cycle block.
module tb;
	import ttlcpu_pkg::*;

	// Branch condition masks: one bit for each of positive, negative and zero.
	localparam logic [2:0] COND_FAR    = 3'b000;
	localparam logic [2:0] COND_GT     = 3'b001;
	localparam logic [2:0] COND_LT     = 3'b010;
	localparam logic [2:0] COND_NE     = 3'b011;
	localparam logic [2:0] COND_EQ     = 3'b100;
	localparam logic [2:0] COND_ALWAYS = 3'b111;

	// Packed so that it lines up with m_axis_tdata, fetch address in the low bits.
	typedef struct packed {
		logic [7:0]  y_value;
		logic [7:0]  x_value;
		logic [7:0]  acc_value;
		logic [7:0]  xout_port;
		logic [7:0]  out_port;
		logic [15:0] fetch_address;
	} cpu_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;

	// Machine state as the testbench expects it.
	logic [15:0] pc;
	logic [7:0]  ir, dr, ac, xr, yr, outr, xoutr, inr;
	logic        prev_sync;
	bit   [7:0]  ram_image [0:RAM_BYTES-1];
	bit          ram_written [0:RAM_BYTES-1];

	cpu_state_t  predicted_states[$];
	int          errors = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          ram_stores = 0;
	int          sync_edges = 0;
	int          taken_branches = 0;
	int          hold_off_cycles = 0;
	logic        idle_on = 1'b0;

	always #5 clk = ~clk;

	ttl_harvard_cpu_cycle uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic logic [15:0] insn(op_t op, logic [2:0] md, bus_t bs, logic [7:0] operand);
		return {operand, op, md, bs};
	endfunction

	// RAM address an instruction would use, given the present x and y.
	function automatic logic [15:0] operand_addr(logic [7:0] opcode, logic [7:0] operand);
		if (opcode[7:5] == OP_BR)
			return {8'h00, operand};
		case (mode_t'(opcode[4:2]))
			MODE_X:              return {8'h00, xr};
			MODE_YD:             return {yr, operand};
			MODE_YX, MODE_OUTINC: return {yr, xr};
			default:             return {8'h00, operand};
		endcase
	endfunction

	// Keeps the next instruction away from RAM bytes that were never written:
	// it is steered onto a written byte of the same page where the operand forms
	// the low address byte, and otherwise takes its operand from the data bus.
	function automatic logic [15:0] ram_safe(logic [15:0] word);
		logic [15:0] a;
		logic        from_operand;
		int          base;
		int          k;
		if (word[1:0] != BUS_RAM || word[7:5] == OP_ST)
			return word;
		a = operand_addr(word[7:0], word[15:8]);
		if (int'(a) >= RAM_BYTES || ram_written[a])
			return word;
		from_operand = (word[7:5] == OP_BR) ||
			!(word[4:2] inside {MODE_X, MODE_YX, MODE_OUTINC});
		if (from_operand) begin
			base = $urandom_range(0, 255);
			for (k = 0; k < 256; k++) begin
				a[7:0] = 8'(base + k);
				if (ram_written[a])
					return {a[7:0], word[7:0]};
			end
		end
		return {word[15:8], word[7:2], BUS_D};
	endfunction

	task automatic reset_machine();
		pc = '0;
		ir = OPC_NOP;
		dr = '0;
		ac = '0;
		xr = '0;
		yr = '0;
		outr = '0;
		xoutr = '0;
		inr = '0;
		prev_sync = 1'b0;
	endtask

	// Executes the instruction held in ir and dr; the new word is latched by the caller.
	task automatic run_machine_cycle(input logic [7:0] port_in);
		op_t         op;
		mode_t       md;
		bus_t        bs;
		tgt_t        tgt;
		logic        inc_x;
		logic [15:0] addr;
		logic [7:0]  bval;
		logic [7:0]  alu;
		int          cond;
		op = op_t'(ir[7:5]);
		md = mode_t'(ir[4:2]);
		bs = bus_t'(ir[1:0]);
		addr = operand_addr(ir, dr);
		tgt = TGT_NONE;
		inc_x = 1'b0;
		if (op != OP_BR) begin
			case (md)
				MODE_XREG: tgt = TGT_X;
				MODE_YREG: tgt = TGT_Y;
				MODE_OUT:  tgt = (op == OP_ST) ? TGT_NONE : TGT_OUT;
				MODE_OUTINC: begin
					tgt = (op == OP_ST) ? TGT_NONE : TGT_OUT;
					inc_x = 1'b1;
				end
				default:   tgt = (op == OP_ST) ? TGT_NONE : TGT_AC;
			endcase
		end
		case (bs)
			BUS_D:   bval = dr;
			BUS_RAM: bval = (op != OP_ST && int'(addr) < RAM_BYTES) ? ram_image[addr] : 8'h00;
			BUS_AC:  bval = ac;
			default: bval = inr;
		endcase
		case (op)
			OP_LD:   alu = bval;
			OP_AND:  alu = ac & bval;
			OP_OR:   alu = ac | bval;
			OP_XOR:  alu = ac ^ bval;
			OP_ADD:  alu = ac + bval;
			OP_SUB:  alu = ac - bval;
			default: alu = ac;
		endcase
		if (op == OP_BR) begin
			if (md != COND_FAR) begin
				cond = ac[7] ? 1 : 0;
				if (ac == 8'h00)
					cond = 2;
				if (ir[2 + cond]) begin
					pc = {pc[15:8], bval};
					taken_branches++;
				end else begin
					pc = pc + 16'd1;
				end
			end else begin
				pc = {yr, bval};
				taken_branches++;
			end
		end else begin
			pc = pc + 16'd1;
		end
		if (op == OP_ST && int'(addr) < RAM_BYTES) begin
			ram_image[addr] = bval;
			ram_written[addr] = 1'b1;
			ram_stores++;
		end
		// The sync bit is seen late, so the old output register counts here.
		if (outr[SYNC_BIT] && !prev_sync) begin
			xoutr = ac;
			inr = port_in;
			sync_edges++;
		end
		prev_sync = outr[SYNC_BIT];
		case (tgt)
			TGT_AC:  ac = alu;
			TGT_X:   xr = alu;
			TGT_Y:   yr = alu;
			TGT_OUT: outr = alu;
			default: ;
		endcase
		if (inc_x)
			xr = xr + 8'd1;
	endtask

	task automatic send_word(input logic [15:0] want);
		logic [7:0]  port;
		logic [15:0] word;
		int          gap;
		port = 8'($urandom_range(0, 255));
		run_machine_cycle(port);
		word = ram_safe(want);
		ir = word[7:0];
		dr = word[15:8];
		predicted_states.push_back({yr, xr, ac, xoutr, outr, pc});
		words_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {port, word};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (predicted_states.size() != 0);
	endtask

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic check_word(input logic [55:0] data);
		cpu_state_t got;
		cpu_state_t want;
		got = data;
		if (predicted_states.size() == 0) begin
			$display("%0t: result word %h arrived with nothing expected", $time, data);
			errors++;
			return;
		end
		want = predicted_states.pop_front();
		words_checked++;
		compare_field("fetch_address", want.fetch_address, got.fetch_address);
		compare_field("out_port", want.out_port, got.out_port);
		compare_field("xout_port", want.xout_port, got.xout_port);
		compare_field("acc_value", want.acc_value, got.acc_value);
		compare_field("x_value", want.x_value, got.x_value);
		compare_field("y_value", want.y_value, got.y_value);
	endtask

	// Loads, every ALU operation, wrap-around and a store fed from the RAM bus.
	task automatic test_alu_ops();
		send_word(insn(OP_LD, MODE_D, BUS_D, 8'h80));
		send_word(insn(OP_ST, MODE_D, BUS_AC, 8'h10));
		send_word(insn(OP_ST, MODE_D, BUS_RAM, 8'h11));
		send_word(insn(OP_LD, MODE_D, BUS_RAM, 8'h10));
		send_word(insn(OP_AND, MODE_D, BUS_D, 8'hFF));
		send_word(insn(OP_OR, MODE_D, BUS_RAM, 8'h11));
		send_word(insn(OP_XOR, MODE_D, BUS_AC, 8'h00));
		send_word(insn(OP_ADD, MODE_D, BUS_D, 8'hFF));
		send_word(insn(OP_SUB, MODE_D, BUS_IN, 8'h01));
	endtask

	// Index registers, the top RAM byte, x wrapping on increment and the space past RAM.
	task automatic test_addressing();
		send_word(insn(OP_LD, MODE_XREG, BUS_D, 8'hFF));
		send_word(insn(OP_LD, MODE_YREG, BUS_D, 8'h7F));
		send_word(insn(OP_ST, MODE_YX, BUS_AC, 8'h00));
		send_word(insn(OP_ST, MODE_OUTINC, BUS_D, 8'h5A));
		send_word(insn(OP_ST, MODE_XREG, BUS_AC, 8'h20));
		send_word(insn(OP_ST, MODE_YREG, BUS_D, 8'h80));
		send_word(insn(OP_LD, MODE_YD, BUS_RAM, 8'h00));
		send_word(insn(OP_ST, MODE_YD, BUS_AC, 8'h01));
	endtask

	// Far jumps and every condition, including a target read from RAM.
	task automatic test_branches();
		send_word(insn(OP_LD, MODE_D, BUS_D, 8'h00));
		send_word(insn(OP_BR, COND_EQ, BUS_D, 8'h40));
		send_word(insn(OP_BR, COND_NE, BUS_AC, 8'h00));
		send_word(insn(OP_BR, COND_FAR, BUS_IN, 8'h00));
		send_word(insn(OP_BR, COND_GT, BUS_RAM, 8'h10));
		send_word(insn(OP_BR, COND_LT, BUS_D, 8'hC3));
		send_word(insn(OP_BR, COND_ALWAYS, BUS_D, 8'h00));
	endtask

	// A rising sync bit copies the accumulator out and samples the input lines.
	task automatic test_io_sync();
		send_word(insn(OP_LD, MODE_OUT, BUS_D, 8'h40));
		send_word(insn(OP_LD, MODE_D, BUS_D, 8'h33));
		send_word(insn(OP_LD, MODE_D, BUS_IN, 8'h00));
		send_word(insn(OP_LD, MODE_OUTINC, BUS_D, 8'h00));
	endtask

	// The receiver holds off while words keep coming, then the sender lets it all drain.
	task automatic test_stall_fill();
		int k;
		hold_off_cycles = 120;
		for (k = 0; k < 24; k++)
			send_word(16'($urandom_range(0, 65535)));
		wait_drained();
	endtask

	task automatic test_random_program(input int count);
		int          k;
		logic [15:0] w;
		for (k = 0; k < count; k++) begin
			if (k >= count - 150)
				idle_on = 1'b0;
			else if (k % 100 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			w = 16'($urandom_range(0, 65535));
			// Extra stores give the RAM reads something to find.
			if ($urandom_range(0, 3) == 0)
				w[7:5] = OP_ST;
			send_word(w);
		end
	endtask

	task automatic finish_run();
		int waited;
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (predicted_states.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (predicted_states.size() != 0) begin
			$display("%0t: %0d expected result words never arrived", $time,
				predicted_states.size());
			errors++;
		end
		$display("Ran %0d program words and checked %0d results: %0d RAM stores,",
			words_sent, words_checked, ram_stores);
		$display("%0d branches taken and %0d sync-bit edges, with stalls on both sides.",
			taken_branches, sync_edges);
		if (errors == 0)
			$display("PASS ttl_harvard_cpu_cycle");
		else
			$display("FAIL ttl_harvard_cpu_cycle");
		$finish;
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_word(m_axis_tdata);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		reset_machine();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_alu_ops();
		test_addressing();
		test_branches();
		test_io_sync();
		test_stall_fill();
		test_random_program(1000);
		finish_run();
	end

	initial begin
		#3_000_000;
		$display("FAIL ttl_harvard_cpu_cycle");
		$finish;
	end

endmodule

// File: ttl_harvard_cpu_cycle.f
hdl/ttlcpu_pkg.sv
hdl/ttlcpu_ram.sv
hdl/ttl_harvard_cpu_cycle.sv
verif/tb.sv
